// ----- rtl/lbp_pkg.sv -----
`default_nettype none

package lbp_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int RESET_DIM    = 200;
    localparam int OBUF_DEPTH   = 3;
    localparam int OBUF_PTR_W   = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W   = $clog2(OBUF_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pix;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // one result word as it sits in the output buffer
    typedef struct packed {
        t_pix code;
        logic last;
    } t_result;

    // 3x3 window, index = row * 3 + column, row 0 is the oldest line
    typedef t_pix t_window [9];

    function automatic logic ge(input t_pix n, input t_pix c);
        return (n >= c);
    endfunction

    function automatic t_pix lbp_code(input t_window w);
        t_pix code;
        code[7] = ge(w[0], w[4]);
        code[6] = ge(w[1], w[4]);
        code[5] = ge(w[2], w[4]);
        code[4] = ge(w[5], w[4]);
        code[3] = ge(w[8], w[4]);
        code[2] = ge(w[7], w[4]);
        code[1] = ge(w[6], w[4]);
        code[0] = ge(w[3], w[4]);
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lbp_ram.sv -----
`default_nettype none

module lbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read and a write to the same entry return the old data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/local_binary_pattern_3x3.sv -----
`default_nettype none

// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  ------------------------------------
// pixel in  in         i_valid / o_stall     i_pixel, i_frame_start
// code out  out        o_valid / i_stall     o_pattern_code, o_last_in_frame
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel word per cycle sustained while o_stall is low; a code word passes the stage 1
// registers and the output buffer before it shows on o_valid. The rate is set by
// the line buffer RAM: one read and one write-back per pixel at the same column address.
// i_rst_n (sync, low) clears counters, window, pipeline and output buffer;
// the line buffers are not cleared, no clearing pass.
// o_stall comes from registers only: it rises when the 3-word output buffer
// plus the word in flight would fill it.

module local_binary_pattern_3x3 #(
    parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // pixel input
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [lbp_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_frame_start,
    // code output
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [lbp_pkg::PIX_W-1:0]     o_pattern_code,
    output logic                               o_last_in_frame,
    // configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lbp_pkg::CFG_W-1:0]     i_cfg_data
);

    import lbp_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    // width wide enough to hold both the raw register and MAX_WIDTH
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int RST_WIDTH = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam int RST_HEIGHT = (RESET_DIM > HEIGHT_LIMIT) ? HEIGHT_LIMIT : RESET_DIM;
    localparam logic [COL_W-1:0] RST_W_LAST = COL_W'(RST_WIDTH - 1);
    localparam logic [ROW_W-1:0] RST_H_LAST = ROW_W'(RST_HEIGHT - 1);
    localparam int LB_W = 2 * PIX_W;

    // ---------------- configuration ----------------
    // Registers are kept as the clamped last index, ready for compare.
    logic [COL_W-1:0] r_w_last;
    logic [ROW_W-1:0] r_h_last;
    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] w_used;
    logic [CMP_W-1:0] h_used;
    logic             cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign cfg_ext     = CMP_W'(i_cfg_data);

    always_comb begin
        w_used = cfg_ext;
        if (cfg_ext < CMP_W'(3)) begin
            w_used = CMP_W'(3);
        end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
            w_used = CMP_W'(MAX_WIDTH);
        end
        h_used = cfg_ext;
        if (cfg_ext < CMP_W'(3)) begin
            h_used = CMP_W'(3);
        end else if (cfg_ext > CMP_W'(HEIGHT_LIMIT)) begin
            h_used = CMP_W'(HEIGHT_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= RST_W_LAST;
            r_h_last <= RST_H_LAST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_w_last <= COL_W'(w_used - CMP_W'(1));
                REG_IMAGE_HEIGHT: r_h_last <= ROW_W'(h_used - CMP_W'(1));
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: accept, position, RAM read ----------------
    logic             in_acc;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] col_in;
    logic [ROW_W-1:0] row_in;
    logic             col_end;
    logic             row_end;

    assign in_acc  = i_valid & ~o_stall;
    assign col_in  = i_frame_start ? '0 : r_col;
    assign row_in  = i_frame_start ? '0 : r_row;
    // a count at or past the last index wraps there (register lowered)
    assign col_end = (col_in >= r_w_last);
    assign row_end = (row_in >= r_h_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : row_in + ROW_W'(1);
            end else begin
                r_col <= col_in + COL_W'(1);
                r_row <= row_in;
            end
        end
    end

    // stage 1 registers
    logic             r_s1_vld;
    logic [COL_W-1:0] r_s1_addr;
    t_pix             r_s1_pix;
    logic             r_s1_emit;
    logic             r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr <= col_in;
            r_s1_pix  <= i_pixel;
            r_s1_emit <= (row_in >= ROW_W'(2)) && (col_in >= COL_W'(2));
            r_s1_last <= col_end & row_end;
        end
    end

    // ---------------- line buffers ----------------
    // Entry at column c: upper byte = row before previous, lower = previous row.
    logic [LB_W-1:0] ram_rdata;
    logic [LB_W-1:0] lb_rd;
    logic [LB_W-1:0] lb_wd;
    t_pix            up1;
    t_pix            up2;

    lbp_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (lb_wd),
        .i_re    (in_acc),
        .i_raddr (col_in),
        .o_rdata (ram_rdata)
    );

    // Write-back of the previous word lands on the same edge as this word's
    // read; the RAM returns old data then, so bypass it.
    logic             r_fw_vld;
    logic [COL_W-1:0] r_fw_addr;
    logic [LB_W-1:0]  r_fw_data;
    logic             fw_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= lb_wd;
        end
    end

    assign fw_hit = r_fw_vld && (r_fw_addr == r_s1_addr);
    assign lb_rd  = fw_hit ? r_fw_data : ram_rdata;
    assign up2    = lb_rd[LB_W-1:PIX_W];
    assign up1    = lb_rd[PIX_W-1:0];
    assign lb_wd  = {up1, r_s1_pix};

    // ---------------- stage 1: window shift and code ----------------
    t_window r_win;
    t_window n_win;
    t_pix    code;

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = up2;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = up1;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    assign code = lbp_code(n_win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_vld) begin
            r_win <= n_win;
        end
    end

    // ---------------- output buffer ----------------
    t_result               r_obuf [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] r_wr_ptr;
    logic [OBUF_PTR_W-1:0] r_rd_ptr;
    logic [OBUF_CNT_W-1:0] r_cnt;
    logic                  push;
    logic                  pop;
    t_result               head;

    assign push = r_s1_vld & r_s1_emit;
    assign pop  = o_valid & ~i_stall;
    assign head = r_obuf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_obuf[r_wr_ptr] <= '{code: code, last: r_s1_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ?
                            '0 : r_wr_ptr + OBUF_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ?
                            '0 : r_rd_ptr + OBUF_PTR_W'(1);
            end
            r_cnt <= r_cnt + OBUF_CNT_W'(push) - OBUF_CNT_W'(pop);
        end
    end

    // room for the word in flight plus the one accepted now
    assign o_stall = ((OBUF_CNT_W + 1)'(r_cnt) + (OBUF_CNT_W + 1)'(r_s1_vld))
                     >= (OBUF_CNT_W + 1)'(OBUF_DEPTH);

    assign o_valid         = (r_cnt != '0);
    assign o_pattern_code  = head.code;
    assign o_last_in_frame = head.last;

    // ---------------- assertions ----------------
    a_obuf_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_cnt < OBUF_CNT_W'(OBUF_DEPTH)))
        else $error("output buffer overflow");

    a_s1_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> $past(in_acc))
        else $error("stage 1 word without accept on the previous edge");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && col_end && row_end) |=> (r_col == '0 && r_row == '0))
        else $error("position counters did not wrap at frame end");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for local_binary_pattern_3x3.
// The main initial block runs one named test task after another. Every test streams
// pixel words through send_pixel. Each accepted pixel goes through predict_lbp at the
// clock edge where it is accepted. predict_lbp keeps its own copy of the line buffers,
// the 3x3 window, the raster counters and the two size registers, and adds the
// expected code word at the tail of expected_codes. The code_checker process drives
// i_stall and compares each accepted code word against the oldest entry in that queue.
//
// The size registers change only while the block is drained. The width grows only in
// front of a pixel that carries frame_start, so a code never uses a line buffer entry
// that was never written.

module tb_top;
    import lbp_pkg::*;

    localparam int LINE_LEN     = DEF_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 8;          // code word trails its pixel through stage 1 and the output buffer
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int MAX_REPORTS  = 40;

    typedef enum int {
        PIX_UNIFORM,   // full 0..255 range
        PIX_NARROW,    // three levels, so many neighbours equal the centre
        PIX_BINARY     // only 0 and 255
    } t_pix_mix;

    // DUT ports; every input has a known value from time zero
    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    t_pix                 i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    t_pix                 o_pattern_code;
    logic                 o_last_in_frame;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // Predictor state.
    // The line buffers are not reset, the same as in the RTL.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_pix             row_above  [LINE_LEN];   // previous row
    t_pix             row_above2 [LINE_LEN];   // the row before that
    t_pix             win3x3     [9];          // index = row * 3 + column, row 0 oldest
    int unsigned      col_pos;
    int unsigned      row_pos;

    t_result     expected_codes [$];
    int unsigned errors       = 0;
    int unsigned pixels_sent  = 0;
    int unsigned cycle_count  = 0;

    // Idling controls, set per phase by the tests.
    // rx_hold_left is counted down inside code_checker.
    bit          tx_gaps_on   = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int unsigned rx_hold_left = 0;

    local_binary_pattern_3x3 DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pattern_code  (o_pattern_code),
        .o_last_in_frame (o_last_in_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic reset_predictor();
        width_reg  = CFG_W'(RESET_DIM);
        height_reg = CFG_W'(RESET_DIM);
        foreach (win3x3[k]) win3x3[k] = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // One accepted pixel word. This queues a code word when the window centre is interior.
    task automatic predict_lbp(input t_pix px, input logic fs);
        int unsigned w, h, c, r;
        t_pix        up1, up2, ctr;
        t_result     res;
        bit          col_last, row_last;
        // out-of-range register values are clamped
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > LINE_LEN) w = LINE_LEN;
        if (h < 3) h = 3;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c >= LINE_LEN) c = 0;

        // both line buffers shift down one row at column c
        up1 = row_above[c];
        up2 = row_above2[c];
        row_above2[c] = up1;
        row_above[c]  = px;

        // window slides left; the new column enters on the right
        win3x3[0] = win3x3[1]; win3x3[1] = win3x3[2]; win3x3[2] = up2;
        win3x3[3] = win3x3[4]; win3x3[4] = win3x3[5]; win3x3[5] = up1;
        win3x3[6] = win3x3[7]; win3x3[7] = win3x3[8]; win3x3[8] = px;

        // a count past the last index (after a shrink) counts as the last one
        col_last = (c >= w - 1);
        row_last = (r >= h - 1);

        if (r >= 2 && c >= 2) begin
            ctr = win3x3[4];
            // bit 7 is top-left, then clockwise; bit 0 is left
            res.code = {win3x3[0] >= ctr, win3x3[1] >= ctr, win3x3[2] >= ctr,
                        win3x3[5] >= ctr, win3x3[8] >= ctr, win3x3[7] >= ctr,
                        win3x3[6] >= ctr, win3x3[3] >= ctr};
            res.last = col_last && row_last;
            expected_codes = {expected_codes, res};
        end

        if (col_last) begin
            col_pos = 0;
            row_pos = row_last ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit enable);
        int unsigned roll;
        if (!enable) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_pix draw_pixel(input t_pix_mix mix);
        case (mix)
            PIX_NARROW: return t_pix'(120 + $urandom_range(0, 2));
            PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:    return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    // Call at a clock edge. Valid stays high when there is no gap; the caller lowers it
    // through drain_codes.
    task automatic send_pixel(input t_pix px, input logic fs);
        int unsigned gap;
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_lbp(px, fs);
        pixels_sent++;
        gap = pick_gap(tx_gaps_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send count pixels. Frame start goes on the first one if fs_first is set, and on
    // the one at restart_at (-1 for none).
    task automatic send_run(input int count, input bit fs_first, input int restart_at,
                            input t_pix_mix mix);
        for (int i = 0; i < count; i++)
            send_pixel(draw_pixel(mix), (i == 0 && fs_first) || (i == restart_at));
    endtask

    // Stop sending and wait for every code word to come back. A trailing border pixel
    // can still be in the pipe, so allow a few more cycles after that.
    task automatic drain_codes();
        i_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers back to back, with the block drained first.
    task automatic program_dims(input int unsigned w_raw, input int unsigned h_raw);
        drain_codes();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_W'(w_raw);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        width_reg = CFG_W'(w_raw);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_W'(h_raw);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        height_reg = CFG_W'(h_raw);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Registers come out of reset at 200x200. The codes at the start of the third row
    // show that the width is 200.
    task automatic test_default_dims();
        send_run(2 * RESET_DIM + 12, 1'b1, -1, PIX_UNIFORM);
    endtask

    // Hand-built 3x3 frames, one code word each.
    task automatic test_code_bits();
        // centre 100; neighbours equal, below and above the centre, across the bits
        t_pix frame_a [9] = '{8'd100, 8'd99, 8'd255,
                              8'd200, 8'd100, 8'd0,
                              8'd0,   8'd100, 8'd101};
        program_dims(3, 3);
        for (int i = 0; i < 9; i++) send_pixel(frame_a[i], i == 0);
        // flat black: every neighbour ties the centre
        for (int i = 0; i < 9; i++) send_pixel(8'd0, i == 0);
        // bright centre, all neighbours below it. No frame_start: the counters wrap.
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd254, 1'b0);
    endtask

    // Register values below 3 and above the limits are clamped.
    task automatic test_dim_limits();
        program_dims(0, 1);                         // used as 3x3
        send_run(9, 1'b1, -1, PIX_NARROW);
        program_dims(11'h7FF, 3);                   // widest line, start of first row
        send_run(30, 1'b1, -1, PIX_UNIFORM);
        program_dims(2, 11'h7FF);                   // tallest frame, narrowest line
        send_run(3 * 6, 1'b1, -1, PIX_BINARY);
    endtask

    // Lower the registers while the counters sit past the new last index.
    task automatic test_shrink_mid_frame();
        program_dims(12, 8);
        send_run(5 * 12 + 7, 1'b1, -1, PIX_UNIFORM);    // stop at row 5, column 7
        program_dims(5, 4);
        send_run(1 + 5 * 4, 1'b0, -1, PIX_NARROW);      // next pixel closes the frame
        program_dims(9, 9);
        send_run(6 * 9 + 2, 1'b1, -1, PIX_BINARY);      // stop at row 6, column 2
        program_dims(9, 3);                             // row 6 becomes the last row
        send_run(7 + 9 * 3, 1'b0, -1, PIX_UNIFORM);
    endtask

    // Frame start in the middle of a frame restarts the counters.
    task automatic test_restart_mid_frame();
        program_dims(7, 6);
        send_run(4 * 7 + 3, 1'b1, -1, PIX_UNIFORM);
        send_run(7 * 6, 1'b1, -1, PIX_UNIFORM);
        send_run(2, 1'b1, 1, PIX_UNIFORM);              // two frame starts in a row
        send_run(7 * 6, 1'b1, 7 * 2 + 4, PIX_NARROW);   // restart inside row two
    endtask

    // The receiver holds off long enough to fill the output buffer and stall the input.
    // Later the sender waits mid-frame until every code word is back.
    task automatic test_backpressure();
        program_dims(16, 10);
        tx_gaps_on   = 1'b0;
        rx_hold_left = 400;
        send_run(16 * 10, 1'b1, -1, PIX_UNIFORM);
        tx_gaps_on = 1'b1;
        send_run(80, 1'b1, -1, PIX_UNIFORM);
        drain_codes();
        send_run(80, 1'b0, -1, PIX_UNIFORM);
    endtask

    // Mostly complete frames with random content. The rest are truncated frames,
    // stray frame starts, mid-frame shrinks and mid-frame pauses.
    task automatic test_random_stream();
        int unsigned goal, w, h, pick, kind, cut;
        bit          fs_next;
        t_pix_mix    mix;
        goal = pixels_sent + 150;
        while (pixels_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                w = $urandom_range(3, 20);
                h = $urandom_range(3, 8);
            end else if (pick < 88) begin
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 2);
            end else if (pick < 95) begin
                w = $urandom_range(21, 80);
                h = $urandom_range(3, 5);
            end else begin
                w = $urandom_range(3, 6);
                h = $urandom_range(20, 40);
            end
            program_dims(w, h);
            if (w < 3) w = 3;
            if (h < 3) h = 3;
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            fs_next      = 1'b1;        // a wider line must start on a fresh frame
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 99);
                mix  = t_pix_mix'($urandom_range(0, 2));
                cut  = $urandom_range(1, w * h - 1);
                if (kind < 70) begin
                    send_run(w * h, fs_next, -1, mix);
                    fs_next = $urandom_range(0, 1);
                end else if (kind < 80) begin
                    send_run(cut, fs_next, -1, mix);
                    fs_next = 1'b1;
                end else if (kind < 88) begin
                    send_run(w * h, fs_next, cut, mix);
                    fs_next = 1'b1;
                end else if (kind < 94) begin
                    send_run(cut, fs_next, -1, mix);
                    w = $urandom_range(3, w);
                    h = $urandom_range(3, h);
                    program_dims(w, h);
                    send_run(w * h, 1'b0, -1, mix);
                    fs_next = 1'b1;
                end else begin
                    send_run(cut, fs_next, -1, mix);
                    drain_codes();
                    send_run(w * h - cut, 1'b0, -1, mix);
                    fs_next = $urandom_range(0, 1);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- code checker

    // Output side. It checks the word taken at this edge, then picks i_stall for the next.
    initial begin : code_checker
        t_result     want;
        int unsigned stall_left;
        int unsigned go_left;
        logic        stall_next;
        stall_left = 0;
        go_left    = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_codes.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected code word %02h last %0b",
                                 $time, o_pattern_code, o_last_in_frame);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_pattern_code !== want.code) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pattern_code expected %02h actual %02h",
                                     $time, want.code, o_pattern_code);
                    end
                    if (o_last_in_frame !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last_in_frame expected %0b actual %0b",
                                     $time, want.last, o_last_in_frame);
                    end
                end
            end
            // a hold-off from a test wins over the random stalls
            if (rx_hold_left > 0) begin
                stall_next = 1'b1;
                rx_hold_left--;
            end else if (!rx_stalls_on) begin
                stall_next = 1'b0;
            end else begin
                if (stall_left == 0 && go_left == 0) begin
                    stall_left = pick_gap(1'b1);
                    go_left    = $urandom_range(1, 8);
                end
                if (stall_left > 0) begin
                    stall_next = 1'b1;
                    stall_left--;
                end else begin
                    stall_next = 1'b0;
                    go_left--;
                end
            end
            i_stall <= stall_next;
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- test sequence

    initial begin
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_dims();
        test_code_bits();
        test_dim_limits();
        test_shrink_mid_frame();
        test_restart_mid_frame();
        test_backpressure();
        test_random_stream();

        drain_codes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
